// File: sv/mtp_pkg.sv
// ============================================================================
// mtp_pkg
// Shared types, codes and helpers of the MessagePack token parser.
// ============================================================================
`default_nettype none

package mtp_pkg;

  // Default sizing of the parser.
  localparam int unsigned MAX_ITEMS_DEF = 65536;
  localparam int unsigned MAX_DEPTH_DEF = 32;

  // Record kinds.
  localparam logic [1:0] KIND_ITEM  = 2'd0;
  localparam logic [1:0] KIND_CLOSE = 2'd1;
  localparam logic [1:0] KIND_DONE  = 2'd2;
  localparam logic [1:0] KIND_ERROR = 2'd3;

  // Error codes.
  localparam logic [1:0] ERR_TRUNC   = 2'd0;
  localparam logic [1:0] ERR_INVALID = 2'd1;
  localparam logic [1:0] ERR_CAP     = 2'd2;

  // Type codes.
  localparam logic [3:0] TY_NIL    = 4'd1;
  localparam logic [3:0] TY_FALSE  = 4'd2;
  localparam logic [3:0] TY_TRUE   = 4'd3;
  localparam logic [3:0] TY_SIGNED = 4'd4;
  localparam logic [3:0] TY_UNSIGN = 4'd5;
  localparam logic [3:0] TY_FLOAT  = 4'd6;
  localparam logic [3:0] TY_DOUBLE = 4'd7;
  localparam logic [3:0] TY_STR    = 4'd8;
  localparam logic [3:0] TY_BIN    = 4'd9;
  localparam logic [3:0] TY_EXT    = 4'd10;
  localparam logic [3:0] TY_ARRAY  = 4'd11;
  localparam logic [3:0] TY_MAP    = 4'd12;

  // Byte decoding phase.
  typedef enum logic [1:0] {
    PH_LEAD,
    PH_HDR,
    PH_SKIP
  } phase_t;

  // Event that one byte causes.
  typedef enum logic [1:0] {
    EV_NONE,
    EV_FAIL,
    EV_CMPL
  } event_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ITEM,
    ST_CHK,
    ST_POP,
    ST_END,
    ST_FLUSH
  } state_t;

  // One result record.
  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] idx;
    logic [3:0]  ty;
    logic [63:0] value;
    logic [31:0] length;
    logic [31:0] offset;
    logic [1:0]  err;
    logic [16:0] total;
    logic        last;
  } rec_t;

  // Decoder result: next header state and the event of this byte.
  typedef struct packed {
    phase_t      phase;
    logic [7:0]  lead;
    logic [63:0] acc;
    logic [3:0]  hdr_left;
    logic [32:0] pay_left;
    event_t      ev;
    logic [1:0]  err;
    logic [3:0]  ty;
    logic [63:0] value;
    logic [31:0] length;
    logic [31:0] offset;
    logic        cont;
    logic [32:0] count;
  } dec_t;

  // Number of header bytes that follow a lead byte.
  function automatic logic [3:0] hdr_size(input logic [7:0] b);
    logic [3:0] r;
    unique case (b)
      8'hc4, 8'hc7, 8'hd9, 8'hcc, 8'hd0: r = 4'd1;
      8'hc5, 8'hc8, 8'hda, 8'hdc, 8'hde, 8'hcd, 8'hd1: r = 4'd2;
      8'hc6, 8'hc9, 8'hdb, 8'hdd, 8'hdf, 8'hce, 8'hd2, 8'hca: r = 4'd4;
      8'hcb, 8'hcf, 8'hd3: r = 4'd8;
      default: r = 4'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// File: sv/mtp_in_if.sv
// ============================================================================
// mtp_in_if
// Input channel: one message byte and the message length per transaction.
// ============================================================================
`default_nettype none

interface mtp_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic [31:0] message_length;

  modport source (output valid, data_byte, message_length, input ready);
  modport sink (input valid, data_byte, message_length, output ready);
endinterface

`default_nettype wire

// File: sv/mtp_out_if.sv
// ============================================================================
// mtp_out_if
// Output channel: one parse record per transaction.
// ============================================================================
`default_nettype none

interface mtp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  record_kind;
  logic [15:0] item_index;
  logic [3:0]  type_code;
  logic [63:0] item_value;
  logic [31:0] item_length;
  logic [31:0] item_offset;
  logic [1:0]  error_code;
  logic [16:0] total_items;
  logic        last_of_run;

  modport source (output valid, record_kind, item_index, type_code, item_value,
                  item_length, item_offset, error_code, total_items, last_of_run,
                  input ready);
  modport sink (input valid, record_kind, item_index, type_code, item_value,
                item_length, item_offset, error_code, total_items, last_of_run,
                output ready);
endinterface

`default_nettype wire

// File: sv/mtp_stack.sv
// ============================================================================
// mtp_stack
// Container stack memory: one write and one registered read per cycle.
// ============================================================================
`default_nettype none

module mtp_stack #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = 5,
  parameter int unsigned DW    = 50
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output      logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: sv/mtp_decode.sv
// ============================================================================
// mtp_decode
// Decodes one message byte against the header state: lead bytes, header
// accumulation, payload skipping and the item event that results.
// ============================================================================
`default_nettype none

module mtp_decode (
  input  wire mtp_pkg::phase_t  phase,
  input  wire logic [7:0]       lead_q,
  input  wire logic [63:0]      acc,
  input  wire logic [3:0]       hdr_left,
  input  wire logic [32:0]      pay_left,
  input  wire logic [7:0]       b,
  input  wire logic [31:0]      rem,
  input  wire logic             cap_hit,
  output      mtp_pkg::dec_t    d
);
  import mtp_pkg::*;

  // Exact widening of a float32 bit pattern to float64.
  function automatic logic [63:0] widen(input logic [31:0] f);
    logic [63:0] r;
    logic [7:0]  e;
    logic [22:0] m;
    logic [4:0]  p;
    logic [10:0] ex;
    logic [51:0] mant;
    e = f[30:23];
    m = f[22:0];
    p = 5'd0;
    for (int i = 0; i < 23; i++) begin
      if (m[i]) begin
        p = 5'(i);
      end
    end
    if (e == 8'hff) begin
      r = {f[31], 11'h7ff, m, 29'd0};
    end else if (e == 8'd0) begin
      if (m == 23'd0) begin
        r = {f[31], 63'd0};
      end else begin
        ex = 11'(p) + 11'd874;
        mant = {29'd0, m} << (6'd52 - 6'(p));
        r = {f[31], ex, mant};
      end
    end else begin
      ex = 11'(e) + 11'd896;
      r = {f[31], ex, m, 29'd0};
    end
    return r;
  endfunction

  logic [63:0] a;
  logic [3:0]  hb;
  logic        is_pay;
  logic [32:0] plen;
  logic [3:0]  ptype;

  always_comb begin
    d = '0;
    d.phase = phase;
    d.lead = lead_q;
    d.acc = acc;
    d.hdr_left = hdr_left;
    d.pay_left = pay_left;
    d.ev = EV_NONE;
    a = {acc[55:0], b};
    hb = hdr_size(b);
    is_pay = 1'b0;
    plen = '0;
    ptype = '0;
    unique case (phase)
      // Header byte: shift in and finish the item on the last one.
      PH_HDR: begin
        d.acc = a;
        d.hdr_left = (hdr_left != 4'd0) ? hdr_left - 4'd1 : 4'd0;
        if (d.hdr_left == 4'd0) begin
          d.phase = PH_LEAD;
          d.ev = EV_CMPL;
          d.ty = TY_SIGNED;
          unique case (lead_q)
            8'hcc, 8'hcd, 8'hce, 8'hd3: d.value = a;
            8'hcf: begin
              d.value = a;
              d.ty = a[63] ? TY_UNSIGN : TY_SIGNED;
            end
            8'hd0: d.value = {{56{a[7]}}, a[7:0]};
            8'hd1: d.value = {{48{a[15]}}, a[15:0]};
            8'hd2: d.value = {{32{a[31]}}, a[31:0]};
            8'hca: begin
              d.ty = TY_FLOAT;
              d.value = widen(a[31:0]);
            end
            8'hcb: begin
              d.ty = TY_DOUBLE;
              d.value = a;
            end
            8'hc4, 8'hc5, 8'hc6: begin
              is_pay = 1'b1;
              ptype = TY_BIN;
              plen = {1'b0, a[31:0]};
            end
            8'hc7, 8'hc8, 8'hc9: begin
              is_pay = 1'b1;
              ptype = TY_EXT;
              plen = {1'b0, a[31:0]} + 33'd1;
            end
            8'hd9, 8'hda, 8'hdb: begin
              is_pay = 1'b1;
              ptype = TY_STR;
              plen = {1'b0, a[31:0]};
            end
            8'hdc, 8'hdd: begin
              d.ty = TY_ARRAY;
              d.length = a[31:0];
              d.cont = 1'b1;
              d.count = {1'b0, a[31:0]};
            end
            default: begin
              d.ty = TY_MAP;
              d.length = a[31:0];
              d.cont = 1'b1;
              d.count = {a[31:0], 1'b0};
            end
          endcase
        end
      end
      // Payload byte: count it off.
      PH_SKIP: begin
        d.pay_left = (pay_left != 33'd0) ? pay_left - 33'd1 : 33'd0;
        if (d.pay_left == 33'd0) begin
          d.phase = PH_LEAD;
        end
      end
      // Lead byte: checks in order, then the item itself.
      default: begin
        if (cap_hit) begin
          d.ev = EV_FAIL;
          d.err = ERR_CAP;
        end else if (b == 8'hc1) begin
          d.ev = EV_FAIL;
          d.err = ERR_INVALID;
        end else if (hb != 4'd0) begin
          if (32'(hb) > rem) begin
            d.ev = EV_FAIL;
            d.err = ERR_TRUNC;
          end else begin
            d.phase = PH_HDR;
            d.lead = b;
            d.acc = '0;
            d.hdr_left = hb;
          end
        end else begin
          d.ev = EV_CMPL;
          if (b <= 8'h7f) begin
            d.ty = TY_SIGNED;
            d.value = {56'd0, b};
          end else if (b <= 8'h8f) begin
            d.ty = TY_MAP;
            d.length = {28'd0, b[3:0]};
            d.cont = 1'b1;
            d.count = {28'd0, b[3:0], 1'b0};
          end else if (b <= 8'h9f) begin
            d.ty = TY_ARRAY;
            d.length = {28'd0, b[3:0]};
            d.cont = 1'b1;
            d.count = {29'd0, b[3:0]};
          end else if (b <= 8'hbf) begin
            d.ev = EV_NONE;
            is_pay = 1'b1;
            ptype = TY_STR;
            plen = {28'd0, b[4:0]};
          end else if (b == 8'hc0) begin
            d.ty = TY_NIL;
          end else if (b == 8'hc2) begin
            d.ty = TY_FALSE;
          end else if (b == 8'hc3) begin
            d.ty = TY_TRUE;
          end else if (b >= 8'hd4 && b <= 8'hd8) begin
            d.ev = EV_NONE;
            is_pay = 1'b1;
            ptype = TY_EXT;
            plen = (33'd1 << (b - 8'hd4)) + 33'd1;
          end else begin
            d.ty = TY_SIGNED;
            d.value = {56'hffffffffffffff, b};
          end
        end
      end
    endcase
    // Items with a payload: check that it fits, then skip it.
    if (is_pay) begin
      if (plen > {1'b0, rem}) begin
        d.ev = EV_FAIL;
        d.err = ERR_TRUNC;
      end else begin
        d.ev = EV_CMPL;
        d.ty = ptype;
        d.value = '0;
        d.length = plen[31:0];
        d.offset = rem;
        d.pay_left = plen;
        d.phase = (plen != 33'd0) ? PH_SKIP : PH_LEAD;
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/messagepack_token_parser_top.sv
// ============================================================================
// messagepack_token_parser_top
// Streaming MessagePack parser that flattens one value per message into
// item, close, done and error records.
// ============================================================================
// Usage:
//   in_ch carries one message byte per transaction together with the length
//   of its message. out_ch carries one record per transaction; last_of_run
//   marks the final record caused by one byte.
//   A byte is taken in ST_IDLE and its item or error is issued in ST_ITEM.
//   A completed item is followed by a check state, ST_CHK, on its
//   container. Each container close and the done record are issued in
//   ST_CHK; a close is followed by ST_POP to reload the next stack entry
//   from memory when one remains below it. ST_END reports truncation and
//   ST_FLUSH hands the last record of the run to the output register.
//   Every byte passes ST_IDLE, ST_ITEM, ST_END and ST_FLUSH in order.
//   The open containers live in a stack memory with a registered read; its
//   top entry is held in registers, so only a pop waits on the memory.
//   Records pass a staging register and an output register, so the parser
//   keeps working while one record waits for the receiver; a longer stall
//   holds the sequencer and in_ch.ready stays low.
//   Reset clears the message state; the stack memory needs no clearing
//   since only entries below the stack pointer are read.
// ============================================================================
`default_nettype none

module messagepack_token_parser_top #(
  parameter int unsigned MAX_ITEMS = mtp_pkg::MAX_ITEMS_DEF,
  parameter int unsigned MAX_DEPTH = mtp_pkg::MAX_DEPTH_DEF
) (
  input wire logic  clk,
  input wire logic  rst,
  mtp_in_if.sink    in_ch,
  mtp_out_if.source out_ch
);
  import mtp_pkg::*;

  localparam int unsigned CW  = $clog2(MAX_ITEMS + 1);
  localparam int unsigned SPW = $clog2(MAX_DEPTH + 1);
  localparam int unsigned AW  = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int unsigned DW  = 33 + CW;

  // Message and header state.
  logic [31:0]  byte_position;
  phase_t       header_phase;
  logic [7:0]   lead_byte;
  logic [63:0]  header_accumulator;
  logic [3:0]   header_bytes_left;
  logic [32:0]  payload_bytes_left;
  logic [CW-1:0] item_counter;
  logic         root_remaining;
  logic [SPW-1:0] stack_pointer;
  logic         message_finished;

  // Top of stack, cached in registers.
  logic [32:0]  tos_rem;
  logic [CW-1:0] tos_idx;

  // Captured byte event.
  dec_t         ev;
  logic         last_byte;

  state_t       state, state_next;
  rec_t         pend, out_rec, rec;
  logic         pend_valid, out_valid;

  dec_t         dec;
  logic [32:0]  next_pos;
  logic         is_last;
  logic [31:0]  rem;
  logic         cap_hit;
  logic         adv, ofree, emit, go, in_acc;
  logic [32:0]  tos_dec;
  logic         depth_fail;

  logic          st_we, st_re;
  logic [AW-1:0] st_waddr, st_raddr;
  logic [DW-1:0] st_wdata, st_rdata;

  // Position within the message and the bytes that still follow.
  assign next_pos = {1'b0, byte_position} + 33'd1;
  assign is_last  = next_pos >= {1'b0, in_ch.message_length};
  assign rem      = is_last ? 32'd0 : (in_ch.message_length - next_pos[31:0]);
  assign cap_hit  = item_counter >= CW'(MAX_ITEMS);

  mtp_decode u_decode (
    .phase    (header_phase),
    .lead_q   (lead_byte),
    .acc      (header_accumulator),
    .hdr_left (header_bytes_left),
    .pay_left (payload_bytes_left),
    .b        (in_ch.data_byte),
    .rem      (rem),
    .cap_hit  (cap_hit),
    .d        (dec)
  );

  // Record staging moves when the staging slot can drain.
  assign ofree   = !out_valid || out_ch.ready;
  assign adv     = !pend_valid || ofree;
  assign in_acc  = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state == ST_IDLE);
  assign tos_dec = (tos_rem != 33'd0) ? tos_rem - 33'd1 : tos_rem;
  assign depth_fail = ev.cont && (32'(stack_pointer) >= 32'(MAX_DEPTH));

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_acc) state_next = ST_ITEM;
      ST_ITEM: begin
        if (adv) begin
          if (ev.ev == EV_CMPL && !depth_fail) state_next = ST_CHK;
          else state_next = ST_END;
        end
      end
      ST_CHK: begin
        if (stack_pointer != '0 ? tos_rem != 33'd0 : root_remaining) begin
          state_next = ST_END;
        end else if (adv) begin
          if (stack_pointer == '0) state_next = ST_END;
          else if (stack_pointer > SPW'(1)) state_next = ST_POP;
          else state_next = ST_CHK;
        end
      end
      ST_POP: state_next = ST_CHK;
      ST_END: begin
        if (!(last_byte && !message_finished) || adv) state_next = ST_FLUSH;
      end
      ST_FLUSH: if (!pend_valid || ofree) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Record to produce and stack port controls.
  always_comb begin
    rec = '0;
    emit = 1'b0;
    go = 1'b0;
    st_we = 1'b0;
    st_re = 1'b0;
    st_waddr = AW'(stack_pointer - SPW'(1));
    st_raddr = AW'(stack_pointer - SPW'(2));
    st_wdata = {tos_dec, tos_idx};
    unique case (state)
      ST_ITEM: begin
        go = adv;
        if (ev.ev == EV_FAIL || (ev.ev == EV_CMPL && depth_fail)) begin
          emit = adv;
          rec.kind = KIND_ERROR;
          rec.err = (ev.ev == EV_FAIL) ? ev.err : ERR_CAP;
        end else if (ev.ev == EV_CMPL) begin
          emit = adv;
          rec.kind = KIND_ITEM;
          rec.idx = 16'(item_counter);
          rec.ty = ev.ty;
          rec.value = ev.value;
          rec.length = ev.length;
          rec.offset = ev.offset;
          st_we = adv && ev.cont && (stack_pointer != '0);
        end
      end
      ST_CHK: begin
        if (!(stack_pointer != '0 ? tos_rem != 33'd0 : root_remaining)) begin
          go = adv;
          emit = adv;
          if (stack_pointer == '0) begin
            rec.kind = KIND_DONE;
            rec.total = 17'(item_counter);
          end else begin
            rec.kind = KIND_CLOSE;
            rec.idx = 16'(tos_idx);
            rec.offset = 32'(item_counter - tos_idx);
            st_re = adv && (stack_pointer > SPW'(1));
          end
        end
      end
      ST_END: begin
        go = adv;
        if (last_byte && !message_finished) begin
          emit = adv;
          rec.kind = KIND_ERROR;
          rec.err = ERR_TRUNC;
        end
      end
      default: begin
      end
    endcase
  end

  mtp_stack #(.DEPTH(MAX_DEPTH), .AW(AW), .DW(DW)) u_stack (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .re    (st_re),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  // State register and record staging.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pend_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && out_ch.ready) begin
        out_valid <= 1'b0;
      end
      if (emit) begin
        if (pend_valid) begin
          out_rec <= pend;
          out_valid <= 1'b1;
        end
        pend <= rec;
        pend_valid <= 1'b1;
      end else if (state == ST_FLUSH && pend_valid && ofree) begin
        // The last record of the run carries the end-of-run flag.
        out_rec <= {pend[$bits(rec_t)-1:1], 1'b1};
        out_valid <= 1'b1;
        pend_valid <= 1'b0;
      end
    end
  end

  // Parser state.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      header_phase <= PH_LEAD;
      lead_byte <= '0;
      header_accumulator <= '0;
      header_bytes_left <= '0;
      payload_bytes_left <= '0;
      item_counter <= '0;
      root_remaining <= 1'b1;
      stack_pointer <= '0;
      message_finished <= 1'b0;
      last_byte <= 1'b0;
      ev <= '0;
    end else begin
      unique case (state)
        // Take the byte and decode it.
        ST_IDLE: begin
          if (in_acc) begin
            last_byte <= is_last;
            byte_position <= is_last ? 32'd0 : next_pos[31:0];
            if (message_finished) begin
              ev <= '0;
            end else begin
              ev <= dec;
              header_phase <= dec.phase;
              lead_byte <= dec.lead;
              header_accumulator <= dec.acc;
              header_bytes_left <= dec.hdr_left;
              payload_bytes_left <= dec.pay_left;
            end
          end
        end
        // Count the item against its parent and push a container.
        ST_ITEM: begin
          if (go) begin
            if (ev.ev == EV_FAIL || (ev.ev == EV_CMPL && depth_fail)) begin
              message_finished <= 1'b1;
            end else if (ev.ev == EV_CMPL) begin
              if (stack_pointer == '0) root_remaining <= 1'b0;
              item_counter <= item_counter + CW'(1);
              if (ev.cont) begin
                tos_rem <= ev.count;
                tos_idx <= item_counter;
                stack_pointer <= stack_pointer + SPW'(1);
              end else begin
                tos_rem <= tos_dec;
              end
            end
          end
        end
        // Close a finished container or end the value.
        ST_CHK: begin
          if (go) begin
            if (stack_pointer == '0) message_finished <= 1'b1;
            else stack_pointer <= stack_pointer - SPW'(1);
          end
        end
        // Reload the new top of stack.
        ST_POP: begin
          tos_rem <= st_rdata[DW-1 -: 33];
          tos_idx <= st_rdata[CW-1:0];
        end
        ST_END: begin
          if (go && last_byte && !message_finished) message_finished <= 1'b1;
        end
        // Rearm at the end of a message.
        ST_FLUSH: begin
          if (state_next == ST_IDLE && last_byte) begin
            header_phase <= PH_LEAD;
            lead_byte <= '0;
            header_accumulator <= '0;
            header_bytes_left <= '0;
            payload_bytes_left <= '0;
            item_counter <= '0;
            root_remaining <= 1'b1;
            stack_pointer <= '0;
            message_finished <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Output channel.
  assign out_ch.valid       = out_valid;
  assign out_ch.record_kind = out_rec.kind;
  assign out_ch.item_index  = out_rec.idx;
  assign out_ch.type_code   = out_rec.ty;
  assign out_ch.item_value  = out_rec.value;
  assign out_ch.item_length = out_rec.length;
  assign out_ch.item_offset = out_rec.offset;
  assign out_ch.error_code  = out_rec.err;
  assign out_ch.total_items = out_rec.total;
  assign out_ch.last_of_run = out_rec.last;

endmodule

`default_nettype wire
